[rtl/qeps_pkg.sv]
// ----------------------------------------------------------------------------
// qeps_pkg
// Shared types, codes and helpers for the quadrature encoder PD servo.
// ----------------------------------------------------------------------------
package qeps_pkg;

    localparam int QEPS_POS_BITS_DEFAULT = 16;

    // fixed field and arithmetic widths
    localparam int QEPS_LIM_W   = 10;   // limits, ids, command argument
    localparam int QEPS_GAIN_W  = 8;
    localparam int QEPS_PROD_W  = QEPS_LIM_W + QEPS_GAIN_W;
    localparam int QEPS_REACT_W = QEPS_PROD_W + 2;
    localparam int QEPS_DATA_W  = 32;
    localparam int QEPS_ADDR_W  = 5;

    // item kinds
    localparam logic [1:0] FUNC_ENC  = 2'd0;
    localparam logic [1:0] FUNC_TICK = 2'd1;
    localparam logic [1:0] FUNC_CMD  = 2'd2;

    // command codes
    localparam logic [3:0] CMD_LISTEN  = 4'd0;
    localparam logic [3:0] CMD_IGNORE  = 4'd1;
    localparam logic [3:0] CMD_ONCE    = 4'd2;
    localparam logic [3:0] CMD_FLAGS   = 4'd3;
    localparam logic [3:0] CMD_TARGET  = 4'd4;
    localparam logic [3:0] CMD_CACHED  = 4'd5;
    localparam logic [3:0] CMD_CURRENT = 4'd6;
    localparam logic [3:0] CMD_POS     = 4'd7;
    localparam logic [3:0] CMD_MODEL   = 4'd8;

    localparam logic [QEPS_LIM_W-1:0] ADDR_ALL   = 10'd256;
    localparam logic [QEPS_LIM_W-1:0] CHAIN_IDLE = 10'd1023;

    // reply tags
    localparam logic [1:0] TAG_POS     = 2'd0;
    localparam logic [1:0] TAG_CURRENT = 2'd1;
    localparam logic [1:0] TAG_MODEL   = 2'd2;

    // listen mode bits
    localparam logic [1:0] LISTEN_ONCE   = 2'b01;
    localparam logic [1:0] LISTEN_ALWAYS = 2'b10;

    // register map (word index)
    localparam logic [2:0] REG_SERVO_ID    = 3'd0;
    localparam logic [2:0] REG_MODEL       = 3'd1;
    localparam logic [2:0] REG_PROP_GAIN   = 3'd2;
    localparam logic [2:0] REG_DERIV_GAIN  = 3'd3;
    localparam logic [2:0] REG_PROP_LIMIT  = 3'd4;
    localparam logic [2:0] REG_DERIV_LIMIT = 3'd5;

    localparam logic [QEPS_LIM_W-1:0]  RST_SERVO_ID    = 10'd0;
    localparam logic [QEPS_LIM_W-1:0]  RST_MODEL       = 10'd13;
    localparam logic [QEPS_GAIN_W-1:0] RST_PROP_GAIN   = 8'd40;
    localparam logic [QEPS_GAIN_W-1:0] RST_DERIV_GAIN  = 8'd30;
    localparam logic [QEPS_LIM_W-1:0]  RST_PROP_LIMIT  = 10'd200;
    localparam logic [QEPS_LIM_W-1:0]  RST_DERIV_LIMIT = 10'd200;

    localparam logic [7:0] DUTY_MAX = 8'd255;

    // encoder step codes, two's complement
    localparam logic [1:0] STEP_NONE = 2'b00;
    localparam logic [1:0] STEP_UP   = 2'b01;
    localparam logic [1:0] STEP_DOWN = 2'b11;

    // fields that ride along with an item to the result register
    typedef struct packed {
        logic        reply_valid;
        logic [15:0] reply_word;
        logic        drive_enabled;
        logic [15:0] shaft_position;
    } qeps_status_t;

    // index is {new pins, old pins}
    function automatic logic [1:0] qeps_quad_step(input logic [3:0] idx);
        logic [1:0] step;
        case (idx) inside
            4'd1, 4'd7, 4'd8, 4'd14:  step = STEP_UP;
            4'd2, 4'd4, 4'd11, 4'd13: step = STEP_DOWN;
            default:                  step = STEP_NONE;
        endcase
        return step;
    endfunction

    // value bits 9..3 go to the high byte, bits 2..0 and tag to the low byte
    function automatic logic [15:0] qeps_pack_reply(input logic [QEPS_LIM_W-1:0] v,
                                                    input logic [1:0] tag);
        return {1'b1, v[9:3], 3'b000, tag, v[2:0]};
    endfunction

endpackage

[rtl/quad_encoder_pd_servo_controller.sv]
// ----------------------------------------------------------------------------
// quad_encoder_pd_servo_controller
// Quadrature position counter, two-byte command decoder and PD loop.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (item_valid/item_ready) carries one item per transfer:
//   func selects an encoder pin sample, a control tick or a command byte.
//   Output channel (result_valid/result_ready) returns exactly one result
//   per item: reply word if a query matched, plus drive duty, direction,
//   enable and the current position count.
//   APB port holds servo_id, model_number, gains and clamp limits; write
//   them only while no item is in flight.
// Timing:
//   Five-stage pipeline (input register, state update, divide-by-ten
//   multiply, gain multiply, reaction/saturation into the result register).
//   A result is valid after its item passes all five registers; one item per
//   cycle is sustained while result_ready is high. Stages advance on their own,
//   so the front takes items while a result waits, until all five are full.
// Reset: all state clears, chain address idles at 1023, config registers
//   return to their defaults.
// ----------------------------------------------------------------------------
module quad_encoder_pd_servo_controller
    import qeps_pkg::*;
#(
    parameter int POS_BITS = QEPS_POS_BITS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // item channel
    input  logic                   item_valid,
    output logic                   item_ready,
    input  logic [1:0]             func,
    input  logic [1:0]             enc_ab,
    input  logic [7:0]             rx_byte,
    // result channel
    output logic                   result_valid,
    input  logic                   result_ready,
    output logic                   reply_valid,
    output logic [15:0]            reply_word,
    output logic [7:0]             pwm_duty,
    output logic                   drive_forward,
    output logic                   drive_enabled,
    output logic signed [15:0]     shaft_position,
    // configuration
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [QEPS_ADDR_W-1:0] paddr,
    input  logic [QEPS_DATA_W-1:0] pwdata,
    output logic [QEPS_DATA_W-1:0] prdata,
    output logic                   pready
);

    // error / 10 as (|err| * M) >> (POS_BITS + 3); exact for all |err| < 2^POS_BITS
    localparam int QW  = POS_BITS - 3;
    localparam int CMPW = (QW > QEPS_LIM_W) ? QW : QEPS_LIM_W;
    localparam logic [POS_BITS-1:0] DIV10_MUL =
        POS_BITS'(((64'd1 << (POS_BITS + 3)) + 64'd9) / 64'd10);

    typedef struct packed {
        logic [1:0] func;
        logic [1:0] enc_ab;
        logic [7:0] rx_byte;
    } stage0_t;

    typedef struct packed {
        logic                tick;
        logic                err_neg;
        logic [POS_BITS-1:0] err_abs;
        logic                dif_neg;
        logic [POS_BITS-1:0] dif_abs;
        qeps_status_t        status;
    } stage1_t;

    typedef struct packed {
        logic                  tick;
        logic                  tp_neg;
        logic [QW-1:0]         quot;
        logic                  td_neg;
        logic [QEPS_LIM_W-1:0] td_mag;
        qeps_status_t          status;
    } stage2_t;

    typedef struct packed {
        logic                   tick;
        logic                   tp_neg;
        logic [QEPS_PROD_W-1:0] p_mag;
        logic                   td_neg;
        logic [QEPS_PROD_W-1:0] d_mag;
        qeps_status_t           status;
    } stage3_t;

    // ---------------------------------------------------------------- config
    logic [QEPS_LIM_W-1:0]  servo_id_reg;
    logic [QEPS_LIM_W-1:0]  model_reg;
    logic [QEPS_GAIN_W-1:0] prop_gain_reg;
    logic [QEPS_GAIN_W-1:0] deriv_gain_reg;
    logic [QEPS_LIM_W-1:0]  prop_limit_reg;
    logic [QEPS_LIM_W-1:0]  deriv_limit_reg;
    logic                   cfg_write;
    logic [2:0]             cfg_index;

    assign pready    = 1'b1;
    assign cfg_index = paddr[QEPS_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            servo_id_reg    <= RST_SERVO_ID;
            model_reg       <= RST_MODEL;
            prop_gain_reg   <= RST_PROP_GAIN;
            deriv_gain_reg  <= RST_DERIV_GAIN;
            prop_limit_reg  <= RST_PROP_LIMIT;
            deriv_limit_reg <= RST_DERIV_LIMIT;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SERVO_ID:    servo_id_reg    <= pwdata[QEPS_LIM_W-1:0];
                REG_MODEL:       model_reg       <= pwdata[QEPS_LIM_W-1:0];
                REG_PROP_GAIN:   prop_gain_reg   <= pwdata[QEPS_GAIN_W-1:0];
                REG_DERIV_GAIN:  deriv_gain_reg  <= pwdata[QEPS_GAIN_W-1:0];
                REG_PROP_LIMIT:  prop_limit_reg  <= pwdata[QEPS_LIM_W-1:0];
                REG_DERIV_LIMIT: deriv_limit_reg <= pwdata[QEPS_LIM_W-1:0];
                default: ;  // writes past the map are dropped
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            REG_SERVO_ID:    prdata = QEPS_DATA_W'(servo_id_reg);
            REG_MODEL:       prdata = QEPS_DATA_W'(model_reg);
            REG_PROP_GAIN:   prdata = QEPS_DATA_W'(prop_gain_reg);
            REG_DERIV_GAIN:  prdata = QEPS_DATA_W'(deriv_gain_reg);
            REG_PROP_LIMIT:  prdata = QEPS_DATA_W'(prop_limit_reg);
            REG_DERIV_LIMIT: prdata = QEPS_DATA_W'(deriv_limit_reg);
            default:         prdata = '0;
        endcase
    end

    // ---------------------------------------------------------- flow control
    // Each stage loads when it is empty or its occupant moves on.
    logic    s0_valid_reg, s1_valid_reg, s2_valid_reg, s3_valid_reg, result_valid_reg;
    logic    out_free, s3_free, s2_free, s1_free, s0_free;
    logic    s0_go, s1_go, s2_go, s3_go, item_take;
    stage0_t s0_reg;
    stage1_t s1_reg, s1_next;
    stage2_t s2_reg, s2_next;
    stage3_t s3_reg, s3_next;
    qeps_status_t result_status_reg;

    assign out_free  = !result_valid_reg || result_ready;
    assign s3_go     = s3_valid_reg && out_free;
    assign s3_free   = !s3_valid_reg || out_free;
    assign s2_go     = s2_valid_reg && s3_free;
    assign s2_free   = !s2_valid_reg || s3_free;
    assign s1_go     = s1_valid_reg && s2_free;
    assign s1_free   = !s1_valid_reg || s2_free;
    assign s0_go     = s0_valid_reg && s1_free;
    assign s0_free   = !s0_valid_reg || s1_free;
    assign item_ready = s0_free;
    assign item_take  = item_valid && item_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg     <= 1'b0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_take)
                s0_valid_reg <= 1'b1;
            else if (s0_go)
                s0_valid_reg <= 1'b0;
            if (s0_go)
                s1_valid_reg <= 1'b1;
            else if (s1_go)
                s1_valid_reg <= 1'b0;
            if (s1_go)
                s2_valid_reg <= 1'b1;
            else if (s2_go)
                s2_valid_reg <= 1'b0;
            if (s2_go)
                s3_valid_reg <= 1'b1;
            else if (s3_go)
                s3_valid_reg <= 1'b0;
            if (s3_go)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (item_take)
            s0_reg <= '{func: func, enc_ab: enc_ab, rx_byte: rx_byte};
        if (s0_go)
            s1_reg <= s1_next;
        if (s1_go)
            s2_reg <= s2_next;
        if (s2_go)
            s3_reg <= s3_next;
        if (s3_go)
            result_status_reg <= s3_reg.status;
    end

    // ------------------------------------------------- state update stage
    logic [POS_BITS-1:0]   enc_position_reg, enc_position_next;
    logic [1:0]            prev_pins_reg, prev_pins_next;
    logic [POS_BITS-1:0]   previous_error_reg, previous_error_next;
    logic [POS_BITS-1:0]   target_reg, target_next;
    logic [POS_BITS-1:0]   cached_reg, cached_next;
    logic [1:0]            listen_mode_reg, listen_mode_next;
    logic [QEPS_LIM_W-1:0] chain_address_reg, chain_address_next;
    logic                  frame_half_reg, frame_half_next;
    logic [3:0]            pending_cmd_reg, pending_cmd_next;
    logic [QEPS_LIM_W-1:0] pending_arg_reg, pending_arg_next;
    logic                  output_on_reg, output_on_next;
    logic [7:0]            duty_reg, duty_next;
    logic                  dir_reg, dir_next;

    logic [POS_BITS-1:0]   err, dif;
    logic [1:0]            step;
    logic [QEPS_LIM_W-1:0] cmd_arg;
    logic                  addr_hit, id_hit;
    logic [31:0]           pos_wide;
    logic                  reply_v;
    logic [15:0]           reply_w;

    assign err      = target_reg - enc_position_reg;
    assign dif      = previous_error_reg - err;
    assign step     = qeps_quad_step({s0_reg.enc_ab, prev_pins_reg});
    assign cmd_arg  = {s0_reg.rx_byte[6:0], pending_arg_reg[2:0]};
    assign id_hit   = (cmd_arg == servo_id_reg);
    assign addr_hit = id_hit || (cmd_arg == ADDR_ALL);

    always_comb
    begin
        enc_position_next   = enc_position_reg;
        prev_pins_next      = prev_pins_reg;
        previous_error_next = previous_error_reg;
        target_next         = target_reg;
        cached_next         = cached_reg;
        listen_mode_next    = listen_mode_reg;
        chain_address_next  = chain_address_reg;
        frame_half_next     = frame_half_reg;
        pending_cmd_next    = pending_cmd_reg;
        pending_arg_next    = pending_arg_reg;
        output_on_next      = output_on_reg;
        reply_v             = 1'b0;
        reply_w             = '0;

        unique case (s0_reg.func)
            FUNC_ENC:
            begin
                enc_position_next = enc_position_reg
                                  + {{(POS_BITS-2){step[1]}}, step};
                prev_pins_next    = s0_reg.enc_ab;
            end
            FUNC_TICK:
            begin
                previous_error_next = err;
            end
            FUNC_CMD:
            begin
                if (!frame_half_reg)
                begin
                    // stray second bytes are dropped here
                    if (!s0_reg.rx_byte[7])
                    begin
                        frame_half_next  = 1'b1;
                        pending_cmd_next = s0_reg.rx_byte[6:3];
                        pending_arg_next = {pending_arg_reg[9:3], s0_reg.rx_byte[2:0]};
                    end
                end
                else
                begin
                    frame_half_next = 1'b0;
                    // a first byte in second position breaks the frame
                    if (s0_reg.rx_byte[7])
                    begin
                        pending_arg_next = cmd_arg;
                        unique case (pending_cmd_reg)
                            CMD_LISTEN:
                            begin
                                chain_address_next = CHAIN_IDLE;
                                if (addr_hit)
                                    listen_mode_next = listen_mode_reg | LISTEN_ALWAYS;
                            end
                            CMD_IGNORE:
                            begin
                                chain_address_next = CHAIN_IDLE;
                                if (addr_hit)
                                    listen_mode_next = 2'b00;
                            end
                            CMD_ONCE:
                            begin
                                chain_address_next = CHAIN_IDLE;
                                if (addr_hit)
                                    listen_mode_next = listen_mode_reg | LISTEN_ONCE;
                                else if (cmd_arg[9])
                                begin
                                    // start a chain at arg - 512
                                    chain_address_next = {1'b0, cmd_arg[8:0]};
                                    listen_mode_next = ({1'b0, cmd_arg[8:0]} == servo_id_reg)
                                                     ? LISTEN_ONCE : 2'b00;
                                end
                            end
                            CMD_FLAGS:
                            begin
                                if (cmd_arg[0])
                                    target_next = cached_reg;
                                if (cmd_arg[3] && (listen_mode_reg != 2'b00))
                                    target_next = enc_position_reg;
                                if (cmd_arg[1])
                                begin
                                    if (listen_mode_reg != 2'b00)
                                        output_on_next = 1'b1;
                                end
                                else if (cmd_arg[2])
                                begin
                                    if (listen_mode_reg != 2'b00)
                                        output_on_next = 1'b0;
                                end
                            end
                            CMD_TARGET:
                            begin
                                if (listen_mode_reg != 2'b00)
                                    target_next = POS_BITS'(cmd_arg);
                            end
                            CMD_CACHED:
                            begin
                                if (listen_mode_reg != 2'b00)
                                    cached_next = POS_BITS'(cmd_arg);
                            end
                            CMD_CURRENT:
                            begin
                                reply_v = id_hit;
                                reply_w = qeps_pack_reply('0, TAG_CURRENT);
                            end
                            CMD_POS:
                            begin
                                reply_v = id_hit;
                                reply_w = qeps_pack_reply(enc_position_reg[QEPS_LIM_W-1:0],
                                                          TAG_POS);
                            end
                            CMD_MODEL:
                            begin
                                reply_v = id_hit;
                                reply_w = qeps_pack_reply(model_reg, TAG_MODEL);
                            end
                            default: ;  // unknown commands do nothing
                        endcase

                        // addressed commands consume the one-time bit, step the chain
                        if ((pending_cmd_reg == CMD_FLAGS) || (pending_cmd_reg == CMD_TARGET)
                            || (pending_cmd_reg == CMD_CACHED))
                        begin
                            listen_mode_next = listen_mode_next & LISTEN_ALWAYS;
                            if (chain_address_reg != CHAIN_IDLE)
                            begin
                                chain_address_next = chain_address_reg + 1'b1;
                                if (chain_address_next == servo_id_reg)
                                    listen_mode_next = LISTEN_ONCE;
                            end
                        end
                    end
                end
            end
            default: ;  // unused kind
        endcase
    end

    assign pos_wide = 32'(enc_position_next);

    always_comb
    begin
        s1_next.tick                  = (s0_reg.func == FUNC_TICK);
        s1_next.err_neg               = err[POS_BITS-1];
        s1_next.err_abs               = err[POS_BITS-1] ? (~err + 1'b1) : err;
        s1_next.dif_neg               = dif[POS_BITS-1];
        s1_next.dif_abs               = dif[POS_BITS-1] ? (~dif + 1'b1) : dif;
        s1_next.status.reply_valid    = reply_v;
        s1_next.status.reply_word     = reply_v ? reply_w : '0;
        s1_next.status.drive_enabled  = output_on_next;
        s1_next.status.shaft_position = pos_wide[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enc_position_reg   <= '0;
            prev_pins_reg      <= '0;
            previous_error_reg <= '0;
            target_reg         <= '0;
            cached_reg         <= '0;
            listen_mode_reg    <= '0;
            chain_address_reg  <= CHAIN_IDLE;
            frame_half_reg     <= 1'b0;
            pending_cmd_reg    <= '0;
            pending_arg_reg    <= '0;
            output_on_reg      <= 1'b0;
        end
        else if (s0_go)
        begin
            enc_position_reg   <= enc_position_next;
            prev_pins_reg      <= prev_pins_next;
            previous_error_reg <= previous_error_next;
            target_reg         <= target_next;
            cached_reg         <= cached_next;
            listen_mode_reg    <= listen_mode_next;
            chain_address_reg  <= chain_address_next;
            frame_half_reg     <= frame_half_next;
            pending_cmd_reg    <= pending_cmd_next;
            pending_arg_reg    <= pending_arg_next;
            output_on_reg      <= output_on_next;
        end
    end

    // --------------------------------------------- divide-by-ten stage
    logic [2*POS_BITS-1:0] div_prod;

    assign div_prod = (2*POS_BITS)'(s1_reg.err_abs) * (2*POS_BITS)'(DIV10_MUL);

    always_comb
    begin
        s2_next.tick   = s1_reg.tick;
        s2_next.tp_neg = s1_reg.err_neg;
        s2_next.quot   = div_prod[2*POS_BITS-1:POS_BITS+3];
        s2_next.td_neg = s1_reg.dif_neg;
        s2_next.td_mag = (s1_reg.dif_abs > POS_BITS'(deriv_limit_reg))
                       ? deriv_limit_reg : s1_reg.dif_abs[QEPS_LIM_W-1:0];
        s2_next.status = s1_reg.status;
    end

    // --------------------------------------------------- gain stage
    logic [CMPW-1:0]       quot_ext;
    logic [QEPS_LIM_W-1:0] tp_mag;

    assign quot_ext = CMPW'(s2_reg.quot);
    assign tp_mag   = (quot_ext > CMPW'(prop_limit_reg))
                    ? prop_limit_reg : quot_ext[QEPS_LIM_W-1:0];

    always_comb
    begin
        s3_next.tick   = s2_reg.tick;
        s3_next.tp_neg = s2_reg.tp_neg;
        s3_next.p_mag  = QEPS_PROD_W'(tp_mag) * QEPS_PROD_W'(prop_gain_reg);
        s3_next.td_neg = s2_reg.td_neg;
        s3_next.d_mag  = QEPS_PROD_W'(s2_reg.td_mag) * QEPS_PROD_W'(deriv_gain_reg);
        s3_next.status = s2_reg.status;
    end

    // ------------------------------------------- reaction / saturation
    logic [QEPS_REACT_W-1:0] p_term, d_term, reaction, react_abs;
    logic                    react_neg;

    assign p_term    = s3_reg.tp_neg ? (~QEPS_REACT_W'(s3_reg.p_mag) + 1'b1)
                                     : QEPS_REACT_W'(s3_reg.p_mag);
    assign d_term    = s3_reg.td_neg ? (~QEPS_REACT_W'(s3_reg.d_mag) + 1'b1)
                                     : QEPS_REACT_W'(s3_reg.d_mag);
    assign reaction  = p_term - d_term;
    assign react_neg = reaction[QEPS_REACT_W-1];
    assign react_abs = react_neg ? (~reaction + 1'b1) : reaction;

    always_comb
    begin
        duty_next = duty_reg;
        dir_next  = dir_reg;
        if (s3_reg.tick)
        begin
            duty_next = (|react_abs[QEPS_REACT_W-1:8]) ? DUTY_MAX : react_abs[7:0];
            dir_next  = !react_neg && (reaction != '0);
        end
    end

    // duty/dir change only when an item enters the result register,
    // so they always match the result on display
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_reg <= '0;
            dir_reg  <= 1'b0;
        end
        else if (s3_go)
        begin
            duty_reg <= duty_next;
            dir_reg  <= dir_next;
        end
    end

    // --------------------------------------------------------- outputs
    assign result_valid   = result_valid_reg;
    assign reply_valid    = result_status_reg.reply_valid;
    assign reply_word     = result_status_reg.reply_word;
    assign drive_enabled  = result_status_reg.drive_enabled;
    assign shaft_position = result_status_reg.shaft_position;
    assign pwm_duty       = duty_reg;
    assign drive_forward  = dir_reg;

    // ------------------------------------------------------- assertions
    a_dir_needs_duty: assert property (@(posedge clk) disable iff (!rst_n)
        dir_reg |-> (duty_reg != '0))
        else $error("forward drive with zero duty");

    a_reply_format: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_status_reg.reply_valid)
            |-> (result_status_reg.reply_word[15] && (result_status_reg.reply_word[7:5] == 3'b000)))
        else $error("malformed reply word");

    a_duty_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(duty_reg) |-> $past(s3_go && s3_reg.tick))
        else $error("duty changed without a control tick");

    a_pos_from_enc: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(enc_position_reg) |-> $past(s0_go && (s0_reg.func == FUNC_ENC)))
        else $error("position changed without an encoder sample");

endmodule
